// File: rtl/core/hwes_pkg.sv
// shared types, constants and state codes for the hour-of-week statistics core
package hwes_pkg;

  localparam int HOURS_PER_DAY = 24;
  localparam int DAYS_PER_WEEK = 7;
  localparam int COUNT_WIDTH   = 32;
  localparam int NUM_BINS      = DAYS_PER_WEEK * HOURS_PER_DAY;
  localparam int BIN_W         = $clog2(NUM_BINS);
  localparam int SLOTS_PER_BIN = 8;
  localparam int AVG_PER_BIN   = 2;
  localparam int AVG_W         = 32;
  localparam int AVG_BASE      = SLOTS_PER_BIN * COUNT_WIDTH;
  localparam int ROW_W         = AVG_BASE + AVG_PER_BIN * AVG_W;

  localparam int CAP_W         = 8;
  localparam logic [CAP_W-1:0] WINDOW_CAP_RESET = 8'd100;

  // dividend is (d-1)*avg + sample
  localparam int DIV_W         = CAP_W + AVG_W + 1;
  localparam int DIV_STEPS     = DIV_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [2:0] KIND_CHUNK_SENT       = 3'd0;
  localparam logic [2:0] KIND_CHUNK_RECEIVED   = 3'd1;
  localparam logic [2:0] KIND_RECEIPT_SENT     = 3'd2;
  localparam logic [2:0] KIND_RECEIPT_RECEIVED = 3'd3;
  localparam logic [2:0] KIND_TIME_IN          = 3'd4;
  localparam logic [2:0] KIND_TIME_OUT         = 3'd5;
  localparam logic [2:0] KIND_POLLUTION        = 3'd6;
  localparam logic [2:0] KIND_MALFORMED        = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  day;
    logic [4:0]  hour;
    logic [31:0] sample;
    logic [31:0] now_seconds;
  } hwes_in_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic [31:0] average_value;
    logic [31:0] last_seen_time;
  } hwes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COUNT,
    ST_MULT,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } hwes_state_t;

  typedef struct packed {
    logic capture;
    logic load_row;
    logic load_count;
    logic load_acc;
    logic div_start;
    logic finish;
  } hwes_cmd_t;

  typedef struct packed {
    logic is_timing;
    logic div_done;
    logic out_busy;
  } hwes_stat_t;

endpackage

// File: rtl/core/hwes_divider.sv
// restoring divider, one quotient bit per cycle, small divisor
module hwes_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hwes_pkg::DIV_W-1:0] dividend,
  input  logic [hwes_pkg::CAP_W-1:0] divisor,
  output logic                      done,
  output logic [hwes_pkg::AVG_W-1:0] quotient
);
  import hwes_pkg::*;

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [CAP_W:0]    rem_r, rem_nxt;
  logic [CAP_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CAP_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r[CAP_W-1:0], quo_r[DIV_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[AVG_W-1:0];

endmodule

// File: rtl/core/hwes_datapath.sv
// bin table, counters, averaging arithmetic and result register
module hwes_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hwes_pkg::hwes_cmd_t   cmd,
  output hwes_pkg::hwes_stat_t  stat,
  input  hwes_pkg::hwes_in_t    in_data,
  input  logic                  cfg_valid,
  input  logic [7:0]            cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hwes_pkg::hwes_out_t   out_data
);
  import hwes_pkg::*;

  logic [ROW_W-1:0]       mem [NUM_BINS];
  logic [NUM_BINS-1:0]    row_vld_r;
  logic [ROW_W-1:0]       rdata_r;
  logic                   rd_vld_r;
  logic [ROW_W-1:0]       row_r;
  hwes_in_t               req_r;
  logic [BIN_W-1:0]       bin_r;
  logic                   in_range_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [CAP_W-1:0]       d_r;
  logic [DIV_W-1:0]       acc_r;
  logic [CAP_W-1:0]       cap_r;
  logic [31:0]            last_seen_r, last_seen_nxt;
  logic                   out_valid_r;
  hwes_out_t              out_r, out_nxt;

  logic                   in_range;
  logic [BIN_W-1:0]       bin_idx;
  logic [BIN_W-1:0]       rd_addr;
  logic                   timing;
  logic                   receive;
  logic                   avg_sel;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [CAP_W-1:0]       d_nxt;
  logic [AVG_W-1:0]       old_avg;
  logic [DIV_W-1:0]       acc_nxt;
  logic [ROW_W-1:0]       row_new;
  logic [AVG_W-1:0]       quot;
  logic                   div_done;

  hwes_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    in_range = (in_data.day < 3'(DAYS_PER_WEEK)) && (in_data.hour < 5'(HOURS_PER_DAY));
    bin_idx  = BIN_W'(in_data.day) * BIN_W'(HOURS_PER_DAY) + BIN_W'(in_data.hour);
    rd_addr  = in_range ? bin_idx : '0;
    timing   = in_range_r &&
               (req_r.command == KIND_TIME_IN || req_r.command == KIND_TIME_OUT);
    receive  = in_range_r &&
               (req_r.command == KIND_CHUNK_RECEIVED ||
                req_r.command == KIND_RECEIPT_RECEIVED);
    avg_sel  = req_r.command[0];
    old_cnt  = row_r[req_r.command*COUNT_WIDTH +: COUNT_WIDTH];
    old_avg  = row_r[AVG_BASE + avg_sel*AVG_W +: AVG_W];
    cnt_nxt  = old_cnt + 1'b1;
    // divisor is the new count clipped to the window, never zero
    if (cnt_nxt > COUNT_WIDTH'(cap_r)) begin
      d_nxt = cap_r;
    end else begin
      d_nxt = CAP_W'(cnt_nxt);
    end
    if (d_nxt == '0) begin
      d_nxt = CAP_W'(1);
    end
    acc_nxt = DIV_W'(d_r - 1'b1) * DIV_W'(old_avg) + DIV_W'(req_r.sample);

    row_new = row_r;
    row_new[req_r.command*COUNT_WIDTH +: COUNT_WIDTH] = cnt_r;
    if (timing) begin
      row_new[AVG_BASE + avg_sel*AVG_W +: AVG_W] = quot;
    end

    last_seen_nxt = receive ? req_r.now_seconds : last_seen_r;
    out_nxt.count_value    = in_range_r ? 32'(cnt_r) : '0;
    out_nxt.average_value  = timing ? quot : '0;
    out_nxt.last_seen_time = last_seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.finish && in_range_r) begin
      mem[bin_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      cap_r       <= WINDOW_CAP_RESET;
      last_seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data[CAP_W-1:0];
      end
      if (cmd.finish) begin
        last_seen_r <= last_seen_nxt;
        if (in_range_r) begin
          row_vld_r[bin_r] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= in_data;
      bin_r      <= rd_addr;
      in_range_r <= in_range;
      rd_vld_r   <= row_vld_r[rd_addr];
    end
    if (cmd.load_row) begin
      // rows never written read as zero
      row_r <= rd_vld_r ? rdata_r : '0;
    end
    if (cmd.load_count) begin
      cnt_r <= cnt_nxt;
      d_r   <= d_nxt;
    end
    if (cmd.load_acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign stat.is_timing = timing;
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// File: rtl/core/hwes_ctrl.sv
// sequencer for one request: read bin, count, multiply, divide (timing events only), write back
module hwes_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hwes_pkg::hwes_stat_t stat,
  output hwes_pkg::hwes_cmd_t  cmd
);
  import hwes_pkg::*;

  hwes_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_COUNT;
      ST_COUNT:  state_nxt = ST_MULT;
      ST_MULT:   state_nxt = stat.is_timing ? ST_DSTART : ST_FIN;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:    if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_READ:   cmd.load_row   = 1'b1;
      ST_COUNT:  cmd.load_count = 1'b1;
      ST_MULT:   cmd.load_acc   = 1'b1;
      ST_DSTART: cmd.div_start  = 1'b1;
      ST_DIV:    cmd            = '0;
      ST_FIN:    cmd.finish     = !stat.out_busy;
      default:   cmd            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/hour_of_week_event_statistics_core.sv
// top level of the hour-of-week event statistics core
// One request is taken at a time. A counter event goes through the read,
// count, multiply and finish states; a timing event (time in, time out) also
// runs the divider, which produces one quotient bit per cycle over a 41-bit
// dividend. The 168-bin table lives in one row-wide memory (one row per
// weekday and hour, eight counters and two averages) with a valid bit per
// row, so reset needs no clearing pass and requests are taken right away.
// The result register lets the next request start while a result waits.
// window_cap may be written at any time through the cfg port, which is
// always ready; write it only while no request is in flight.
module hour_of_week_event_statistics_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hwes_pkg::hwes_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hwes_pkg::hwes_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import hwes_pkg::*;

  hwes_cmd_t  cmd;
  hwes_stat_t stat;

  hwes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hwes_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign cfg_ready = 1'b1;

endmodule
